// File: src/sdbs_pkg.sv
// Package for the score descending box sorter.
// Holds box field widths, the packed box type and the sequencer state type.
// No dependencies.
package sdbs_pkg;

    localparam int COORD_W = 12;
    localparam int SCORE_W = 24;
    localparam int BOX_W   = 2 * COORD_W + SCORE_W;

    typedef struct packed {
        logic [COORD_W-1:0]        x;
        logic [COORD_W-1:0]        y;
        logic signed [SCORE_W-1:0] score;
    } box_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_P_RD,
        ST_P_LD,
        ST_Q_RUN,
        ST_P_WB,
        ST_OUT_RD,
        ST_OUT_LD
    } sort_state_t;

endpackage

// File: src/sdbs_ram.sv
// Generic simple dual port RAM: one write port, one read port, registered read.
// Read data holds while rd_en is low. No dependencies.
module sdbs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/score_descending_box_sorter_unit.sv
// Loading writes each accepted box to the store until it is full. After the last_box beat
// the sort runs over the n stored boxes, one compare per cycle on the shared comparator and
// store port, then each sorted box leaves via a read and a load step; out_stall holds the load.
// Input is stalled from the last_box beat until the final result is in the output register.
// Reset clears the sequencer, box count and output valid; the box store is not cleared.
// Depends on sdbs_pkg and sdbs_ram.
module score_descending_box_sorter_unit #(
    parameter int MAX_BOXES = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [sdbs_pkg::COORD_W-1:0]        box_x,
    input  logic [sdbs_pkg::COORD_W-1:0]        box_y,
    input  logic signed [sdbs_pkg::SCORE_W-1:0] box_score,
    input  logic                                last_box,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sdbs_pkg::COORD_W-1:0]        sorted_x,
    output logic [sdbs_pkg::COORD_W-1:0]        sorted_y,
    output logic signed [sdbs_pkg::SCORE_W-1:0] sorted_score,
    output logic                                sorted_last
);

    import sdbs_pkg::*;

    localparam int AW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);

    sort_state_t     state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   p_reg, p_next;
    logic [AW-1:0]   q_reg, q_next;
    logic [AW-1:0]   k_reg, k_next;
    logic            out_valid_reg, out_valid_next;
    box_t            cur_reg, cur_next;
    box_t            out_box_reg, out_box_next;
    logic            out_last_reg, out_last_next;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    box_t            wr_box;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [BOX_W-1:0] rd_data;
    box_t            rd_box;

    logic            in_beat;
    logic            out_beat;
    logic            full;
    logic            last_q;
    logic            last_p;
    logic            last_k;
    logic            swap;
    logic            slot_free;

    sdbs_ram #(
        .WIDTH (BOX_W),
        .DEPTH (MAX_BOXES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_box),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_box    = box_t'(rd_data);
    assign in_stall  = (state_reg != ST_LOAD);
    assign in_beat   = in_valid && !in_stall;
    assign out_beat  = out_valid_reg && !out_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign full      = (count_reg == CW'(MAX_BOXES));
    assign last_q    = ((CW'(q_reg) + CW'(1)) == count_reg);
    assign last_p    = ((CW'(p_reg) + CW'(1)) == count_reg);
    assign last_k    = ((CW'(k_reg) + CW'(1)) == count_reg);
    assign swap      = (q_reg != p_reg) && ($signed(cur_reg.score) > $signed(rd_box.score));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            p_reg         <= '0;
            q_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            p_reg         <= p_next;
            q_reg         <= q_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_box_reg  <= out_box_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        out_box_next   = out_box_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !out_beat;
        wr_en          = 1'b0;
        wr_addr        = count_reg[AW-1:0];
        wr_box         = '{x: box_x, y: box_y, score: box_score};
        rd_en          = 1'b0;
        rd_addr        = p_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_beat)
                begin
                    if (!full)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    if (last_box)
                    begin
                        p_next     = '0;
                        state_next = ST_P_RD;
                    end
                end
            end
            ST_P_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = p_reg;
                state_next = ST_P_LD;
            end
            ST_P_LD:
            begin
                cur_next   = rd_box;
                rd_en      = 1'b1;
                rd_addr    = '0;
                q_next     = '0;
                state_next = ST_Q_RUN;
            end
            ST_Q_RUN:
            begin
                if (swap)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = q_reg;
                    wr_box   = cur_reg;
                    cur_next = rd_box;
                end
                rd_addr = q_reg + AW'(1);
                if (last_q)
                begin
                    state_next = ST_P_WB;
                end
                else
                begin
                    rd_en  = 1'b1;
                    q_next = q_reg + AW'(1);
                end
            end
            ST_P_WB:
            begin
                wr_en   = 1'b1;
                wr_addr = p_reg;
                wr_box  = cur_reg;
                rd_addr = p_reg + AW'(1);
                if (last_p)
                begin
                    k_next     = '0;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    p_next     = p_reg + AW'(1);
                    state_next = ST_P_LD;
                end
            end
            ST_OUT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = k_reg;
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                if (slot_free)
                begin
                    out_box_next   = rd_box;
                    out_last_next  = last_k;
                    out_valid_next = 1'b1;
                    if (last_k)
                    begin
                        count_next = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + AW'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign sorted_x     = out_box_reg.x;
    assign sorted_y     = out_box_reg.y;
    assign sorted_score = out_box_reg.score;
    assign sorted_last  = out_last_reg;

endmodule
